// ===== hw/rtl/rppa_pkg.sv =====
// ---------------------------------------------------------------------------
// rppa_pkg
// Shared types and constants of the page pool allocator: field widths,
// action and status codes, queue entry and back end state encodings.
// ---------------------------------------------------------------------------
package rppa_pkg;

   localparam int HANDLE_W    = 13;
   localparam int ACTION_W    = 3;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 16;
   localparam int NEED1_W     = HANDLE_W + 1;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOCATE         = 3'd0,
      ACT_ADD_REFERENCE    = 3'd1,
      ACT_RELEASE          = 3'd2,
      ACT_DUPLICATE        = 3'd3,
      ACT_DUPLICATE_SHARED = 3'd4,
      ACT_CHECK_AVAILABLE  = 3'd5,
      ACT_VALIDATE         = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_NO_MEMORY    = 3'd1,
      ST_SLOT_BUSY    = 3'd2,
      ST_SLOT_EMPTY   = 3'd3,
      ST_OUT_OF_POOL  = 3'd4,
      ST_NOT_IN_USE   = 3'd5,
      ST_REF_OVERFLOW = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      BK_FETCH,
      BK_EXEC,
      BK_FIX
   } back_state_type;

   // classified request as it sits in the queue
   typedef struct packed {
      action_type          action;
      logic [HANDLE_W-1:0] slot_handle;
      logic [HANDLE_W-1:0] page_handle;
      logic [NEED1_W-1:0]  need_plus_one;
      logic                slot_zero;
      logic                page_zero;
      logic                slot_eq_page;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ===== hw/rtl/rppa_if.sv =====
// ---------------------------------------------------------------------------
// rppa request and response channels
// Valid/ready channels of the allocator; a beat moves when both are high.
// ---------------------------------------------------------------------------
interface rppa_req_if;
   logic                          valid;
   logic                          ready;
   logic [rppa_pkg::ACTION_W-1:0] action;
   logic [rppa_pkg::HANDLE_W-1:0] slot_handle;
   logic [rppa_pkg::HANDLE_W-1:0] page_handle;
   logic [rppa_pkg::HANDLE_W-1:0] need_pages;

   modport source (output valid, action, slot_handle, page_handle, need_pages,
                   input ready);
   modport sink   (input valid, action, slot_handle, page_handle, need_pages,
                   output ready);
endinterface

interface rppa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [rppa_pkg::STATUS_W-1:0] status;
   logic [rppa_pkg::HANDLE_W-1:0] result_handle;
   logic [rppa_pkg::COUNT_W-1:0]  ref_count;
   logic                          available;
   logic [rppa_pkg::HANDLE_W-1:0] used_pages;

   modport source (output valid, ok, status, result_handle, ref_count, available,
                   used_pages, input ready);
   modport sink   (input valid, ok, status, result_handle, ref_count, available,
                   used_pages, output ready);
endinterface

// ===== hw/rtl/rppa_ram.sv =====
// ---------------------------------------------------------------------------
// rppa_ram
// Generic single write, single read memory with registered read data.
// ---------------------------------------------------------------------------
module rppa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rppa_front.sv =====
// ---------------------------------------------------------------------------
// rppa_front
// Takes request beats, decodes the action and precomputes handle compares
// before the item enters the queue.
// ---------------------------------------------------------------------------
module rppa_front (
   rppa_req_if.sink          req,
   input  logic              q_full,
   output logic              q_push,
   output rppa_pkg::cmd_type q_cmd
);

   localparam int NW = rppa_pkg::NEED1_W;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      q_cmd.action        = rppa_pkg::action_type'(req.action);
      q_cmd.slot_handle   = req.slot_handle;
      q_cmd.page_handle   = req.page_handle;
      q_cmd.need_plus_one = NW'(req.need_pages) + NW'(1);
      q_cmd.slot_zero     = (req.slot_handle == '0);
      q_cmd.page_zero     = (req.page_handle == '0);
      q_cmd.slot_eq_page  = (req.slot_handle == req.page_handle);
   end

endmodule

// ===== hw/rtl/rppa_fifo.sv =====
// ---------------------------------------------------------------------------
// rppa_fifo
// Short queue of classified requests between front and back end.
// ---------------------------------------------------------------------------
module rppa_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rppa_pkg::cmd_type          push_data,
   input  logic                       pop,
   output rppa_pkg::cmd_type          head,
   output rppa_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rppa_pkg::cmd_type  entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

endmodule

// ===== hw/rtl/rppa_back.sv =====
// ---------------------------------------------------------------------------
// rppa_back
// Executes queued requests against the count and link memories, keeps the
// free list head and pool counters, and holds the response register.
// ---------------------------------------------------------------------------
module rppa_back #(
   parameter int POOL_PAGES = 4096,
   parameter int REF_BITS   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rppa_pkg::cmd_type          q_head,
   input  rppa_pkg::queue_status_type q_status,
   output logic                       q_pop,
   rppa_rsp_if.source                 rsp
);

   localparam int IDX_W = $clog2(POOL_PAGES);
   localparam int CNT_W = $clog2(POOL_PAGES + 1);
   localparam int HW    = rppa_pkg::HANDLE_W;
   localparam int OW    = rppa_pkg::COUNT_W;
   localparam int CMP_W = (CNT_W > HW + 1) ? CNT_W : HW + 1;
   localparam int RCW   = (REF_BITS > OW) ? REF_BITS : OW;
   localparam logic [CMP_W-1:0]    POOL_C  = CMP_W'(POOL_PAGES);
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

   rppa_pkg::back_state_type state_ff, state_in;
   rppa_pkg::cmd_type        cmd_ff, cmd_in;

   logic [IDX_W-1:0]    free_head_ff, free_head_in;
   logic [CNT_W-1:0]    free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0]    blank_cnt_ff, blank_cnt_in;
   logic [IDX_W-1:0]    fix_idx_ff, fix_idx_in;
   logic [REF_BITS-1:0] fix_val_ff, fix_val_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                ok_ff, ok_in;
   rppa_pkg::status_type status_ff, status_in;
   logic [HW-1:0]       handle_ff, handle_in;
   logic [OW-1:0]       count_ff, count_in;
   logic                avail_ff, avail_in;
   logic [HW-1:0]       used_ff, used_in;

   // fsm outputs
   logic exec_fire;
   logic fix_wr;

   // memory ports
   logic [CMP_W-1:0]    head_slot_m1, head_page_m1;
   logic [REF_BITS-1:0] ref_s, ref_p;
   logic [IDX_W-1:0]    link_d;
   logic                ref_we;
   logic [IDX_W-1:0]    ref_wa;
   logic [REF_BITS-1:0] ref_wd;
   logic                link_we;

   // execute datapath
   logic [CMP_W-1:0]    limit, slot_x, page_x, slot_m1, page_m1, new_h, used_x, avail_sum;
   logic [IDX_W-1:0]    slot_idx, page_idx, new_idx, head_mid;
   logic                slot_in_pool, page_in_pool, has_free, has_blank, can_take;
   rppa_pkg::status_type slot_err, page_err;
   logic [REF_BITS-1:0] slot_count, ref_s_dec, ref_p_inc, res_count;
   logic                do_take, do_bump, do_drop, need_fix, push_free;
   logic [CNT_W-1:0]    free_mid, free_next, blank_next;
   logic                res_ok;
   rppa_pkg::status_type res_status;
   logic [HW-1:0]       res_handle;
   logic [RCW-1:0]      res_count_x;

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rppa_pkg::BK_FETCH: begin
            if (!q_status.empty) begin
               state_in = rppa_pkg::BK_EXEC;
            end
         end
         rppa_pkg::BK_EXEC: begin
            if (exec_fire) begin
               state_in = need_fix ? rppa_pkg::BK_FIX : rppa_pkg::BK_FETCH;
            end
         end
         rppa_pkg::BK_FIX: begin
            state_in = rppa_pkg::BK_FETCH;
         end
         default: begin
            state_in = rppa_pkg::BK_FETCH;
         end
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      exec_fire = 1'b0;
      fix_wr    = 1'b0;
      case (state_ff)
         rppa_pkg::BK_FETCH: begin
            q_pop = !q_status.empty;
         end
         rppa_pkg::BK_EXEC: begin
            exec_fire = !rsp_valid_ff || rsp.ready;
         end
         rppa_pkg::BK_FIX: begin
            fix_wr = 1'b1;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // ---------------- memories ----------------
   assign head_slot_m1 = CMP_W'(q_head.slot_handle) - CMP_W'(1);
   assign head_page_m1 = CMP_W'(q_head.page_handle) - CMP_W'(1);

   // two copies of the count store give one read port per handle
   rppa_ram #(.WIDTH(REF_BITS), .DEPTH(POOL_PAGES)) u_ref_slot (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_wa),
      .wr_data (ref_wd),
      .rd_en   (q_pop),
      .rd_addr (head_slot_m1[IDX_W-1:0]),
      .rd_data (ref_s)
   );

   rppa_ram #(.WIDTH(REF_BITS), .DEPTH(POOL_PAGES)) u_ref_page (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_wa),
      .wr_data (ref_wd),
      .rd_en   (q_pop),
      .rd_addr (head_page_m1[IDX_W-1:0]),
      .rd_data (ref_p)
   );

   rppa_ram #(.WIDTH(IDX_W), .DEPTH(POOL_PAGES)) u_link (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (slot_idx),
      .wr_data (head_mid),
      .rd_en   (q_pop),
      .rd_addr (free_head_ff),
      .rd_data (link_d)
   );

   // ---------------- execute datapath ----------------
   always_comb begin
      // pages at or above the blank boundary were never written
      limit        = POOL_C - CMP_W'(blank_cnt_ff);
      slot_x       = CMP_W'(cmd_ff.slot_handle);
      page_x       = CMP_W'(cmd_ff.page_handle);
      slot_m1      = slot_x - CMP_W'(1);
      page_m1      = page_x - CMP_W'(1);
      slot_idx     = slot_m1[IDX_W-1:0];
      page_idx     = page_m1[IDX_W-1:0];
      slot_in_pool = !cmd_ff.slot_zero && (slot_x <= limit);
      page_in_pool = !cmd_ff.page_zero && (page_x <= limit);
      slot_count   = slot_in_pool ? ref_s : '0;
      ref_s_dec    = ref_s - REF_BITS'(1);
      ref_p_inc    = ref_p + REF_BITS'(1);

      if (cmd_ff.slot_zero) begin
         slot_err = rppa_pkg::ST_SLOT_EMPTY;
      end else if (!slot_in_pool) begin
         slot_err = rppa_pkg::ST_OUT_OF_POOL;
      end else if (ref_s == '0) begin
         slot_err = rppa_pkg::ST_NOT_IN_USE;
      end else begin
         slot_err = rppa_pkg::ST_OK;
      end

      if (cmd_ff.page_zero) begin
         page_err = rppa_pkg::ST_SLOT_EMPTY;
      end else if (!page_in_pool) begin
         page_err = rppa_pkg::ST_OUT_OF_POOL;
      end else if (ref_p == '0) begin
         page_err = rppa_pkg::ST_NOT_IN_USE;
      end else begin
         page_err = rppa_pkg::ST_OK;
      end

      has_free  = (free_cnt_ff != '0);
      has_blank = (blank_cnt_ff != '0);
      can_take  = has_free || has_blank;
      new_idx   = has_free ? free_head_ff : limit[IDX_W-1:0];
      new_h     = CMP_W'(new_idx) + CMP_W'(1);

      res_ok     = 1'b0;
      res_status = rppa_pkg::ST_OK;
      res_handle = cmd_ff.slot_handle;
      res_count  = slot_count;
      do_take    = 1'b0;
      do_bump    = 1'b0;
      do_drop    = 1'b0;

      case (cmd_ff.action)
         rppa_pkg::ACT_ALLOCATE: begin
            if (!cmd_ff.slot_zero) begin
               res_status = rppa_pkg::ST_SLOT_BUSY;
            end else if (!can_take) begin
               res_status = rppa_pkg::ST_NO_MEMORY;
            end else begin
               do_take    = 1'b1;
               res_ok     = 1'b1;
               res_handle = new_h[HW-1:0];
               res_count  = REF_BITS'(1);
            end
         end
         rppa_pkg::ACT_ADD_REFERENCE: begin
            if (cmd_ff.page_zero) begin
               res_status = rppa_pkg::ST_SLOT_EMPTY;
            end else if (!page_in_pool) begin
               res_status = rppa_pkg::ST_OUT_OF_POOL;
            end else if (!cmd_ff.slot_zero) begin
               // slot already holding this page counts as success
               if (cmd_ff.slot_eq_page) begin
                  res_ok = 1'b1;
               end else begin
                  res_status = rppa_pkg::ST_SLOT_BUSY;
               end
            end else if (ref_p == '0) begin
               res_status = rppa_pkg::ST_NOT_IN_USE;
            end else if (ref_p == REF_MAX) begin
               res_status = rppa_pkg::ST_REF_OVERFLOW;
            end else begin
               do_bump    = 1'b1;
               res_ok     = 1'b1;
               res_handle = cmd_ff.page_handle;
               res_count  = ref_p_inc;
            end
         end
         rppa_pkg::ACT_RELEASE: begin
            if (slot_err != rppa_pkg::ST_OK) begin
               res_status = slot_err;
            end else begin
               do_drop    = 1'b1;
               res_ok     = 1'b1;
               res_handle = '0;
               res_count  = '0;
            end
         end
         rppa_pkg::ACT_DUPLICATE, rppa_pkg::ACT_DUPLICATE_SHARED: begin
            if (slot_err != rppa_pkg::ST_OK) begin
               res_status = slot_err;
            end else if (cmd_ff.action == rppa_pkg::ACT_DUPLICATE_SHARED &&
                         ref_s <= REF_BITS'(1)) begin
               res_ok = 1'b1;
            end else if (!can_take) begin
               res_status = rppa_pkg::ST_NO_MEMORY;
            end else begin
               do_take    = 1'b1;
               do_drop    = 1'b1;
               res_ok     = 1'b1;
               res_handle = new_h[HW-1:0];
               res_count  = REF_BITS'(1);
            end
         end
         rppa_pkg::ACT_CHECK_AVAILABLE: begin
            res_ok = 1'b1;
         end
         rppa_pkg::ACT_VALIDATE: begin
            if (page_err != rppa_pkg::ST_OK) begin
               res_status = page_err;
            end else begin
               res_ok = 1'b1;
            end
         end
         default: begin
            res_ok = 1'b0;
         end
      endcase

      need_fix = do_take && do_drop;

      // pop from free list or blank region, then push of the dropped page
      head_mid   = (do_take && has_free) ? link_d : free_head_ff;
      free_mid   = (do_take && has_free) ? free_cnt_ff - CNT_W'(1) : free_cnt_ff;
      blank_next = (do_take && !has_free) ? blank_cnt_ff - CNT_W'(1) : blank_cnt_ff;
      push_free  = do_drop && (ref_s_dec == '0);
      free_next  = push_free ? free_mid + CNT_W'(1) : free_mid;

      avail_sum   = CMP_W'(free_next) + CMP_W'(blank_next);
      used_x      = POOL_C - CMP_W'(blank_next) - CMP_W'(free_next);
      res_count_x = RCW'(res_count);
   end

   // count store write port: execute writes first, fix cycle writes the drop
   always_comb begin
      ref_we = 1'b0;
      ref_wa = slot_idx;
      ref_wd = ref_s_dec;
      if (fix_wr) begin
         ref_we = 1'b1;
         ref_wa = fix_idx_ff;
         ref_wd = fix_val_ff;
      end else if (exec_fire) begin
         ref_we = do_take || do_bump || do_drop;
         if (do_take) begin
            ref_wa = new_idx;
            ref_wd = REF_BITS'(1);
         end else if (do_bump) begin
            ref_wa = page_idx;
            ref_wd = ref_p_inc;
         end
      end
   end

   assign link_we = exec_fire && push_free;

   // ---------------- next values ----------------
   always_comb begin
      cmd_in       = q_pop ? q_head : cmd_ff;
      free_head_in = free_head_ff;
      free_cnt_in  = free_cnt_ff;
      blank_cnt_in = blank_cnt_ff;
      fix_idx_in   = fix_idx_ff;
      fix_val_in   = fix_val_ff;
      ok_in        = ok_ff;
      status_in    = status_ff;
      handle_in    = handle_ff;
      count_in     = count_ff;
      avail_in     = avail_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (exec_fire) begin
         free_head_in = push_free ? slot_idx : head_mid;
         free_cnt_in  = free_next;
         blank_cnt_in = blank_next;
         fix_idx_in   = slot_idx;
         fix_val_in   = ref_s_dec;
         ok_in        = res_ok;
         status_in    = res_status;
         handle_in    = res_handle;
         count_in     = res_count_x[OW-1:0];
         avail_in     = (avail_sum > CMP_W'(cmd_ff.need_plus_one));
         used_in      = used_x[HW-1:0];
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rppa_pkg::BK_FETCH;
         rsp_valid_ff <= 1'b0;
         free_head_ff <= '0;
         free_cnt_ff  <= '0;
         blank_cnt_ff <= CNT_W'(POOL_PAGES);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_head_ff <= free_head_in;
         free_cnt_ff  <= free_cnt_in;
         blank_cnt_ff <= blank_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      fix_idx_ff <= fix_idx_in;
      fix_val_ff <= fix_val_in;
      ok_ff      <= ok_in;
      status_ff  <= status_in;
      handle_ff  <= handle_in;
      count_ff   <= count_in;
      avail_ff   <= avail_in;
      used_ff    <= used_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.ok            = ok_ff;
   assign rsp.status        = status_ff;
   assign rsp.result_handle = handle_ff;
   assign rsp.ref_count     = count_ff;
   assign rsp.available     = avail_ff;
   assign rsp.used_pages    = used_ff;

endmodule

// ===== hw/rtl/refcounted_page_pool_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// refcounted_page_pool_allocator_unit
// Page pool with per-page reference counts, a linked free list and a blank
// region; a front end queues decoded requests, a back end executes them.
// ---------------------------------------------------------------------------
//  channel   | dir | handshake         | payload
//  req_chan  | in  | valid/ready beat  | action, slot_handle, page_handle, need_pages
//  rsp_chan  | out | valid/ready beat  | ok, status, result_handle, ref_count,
//            |     |                   | available, used_pages
//
//  the back end handles one item at a time (memory read in fetch, then execute
//  and write); a duplicate that takes a new page also passes through fix, as the count
//  memory's single write port is used twice
//  synchronous reset, no memory clearing pass: pages past the blank boundary
//  are treated as never written
//  a 2 entry queue decouples req_chan; a stalled rsp_chan holds the back end
//  in execute while the queue keeps filling
// ---------------------------------------------------------------------------
module refcounted_page_pool_allocator_unit #(
   parameter int POOL_PAGES = 4096,
   parameter int REF_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   rppa_req_if.sink   req_chan,
   rppa_rsp_if.source rsp_chan
);

   logic                       q_push;
   logic                       q_pop;
   rppa_pkg::cmd_type          q_cmd;
   rppa_pkg::cmd_type          q_head;
   rppa_pkg::queue_status_type q_status;

   rppa_front u_front (
      .req    (req_chan),
      .q_full (q_status.full),
      .q_push (q_push),
      .q_cmd  (q_cmd)
   );

   rppa_fifo #(.DEPTH(rppa_pkg::QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_cmd),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   rppa_back #(.POOL_PAGES(POOL_PAGES), .REF_BITS(REF_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp      (rsp_chan)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("back end popped an empty queue");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("front end pushed into a full queue");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> !q_status.empty)
      else $error("queued beat lost");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> q_status.empty)
      else $error("queue not empty after reset");

endmodule
